@@ rtl/bsr_pkg.sv @@
// ----------------------------------------------------------------------------
// bsr_pkg: shared types and constants of the battery status reporter
// Holds the divider command type, the widths of the divider datapath and the
// codes that the reporter drives on its state outputs.
// ----------------------------------------------------------------------------
package bsr_pkg;

	// Divider datapath: two quotient bits are retired per cycle.
	localparam int unsigned DIV_NUM_W  = 34;
	localparam int unsigned DIV_DEN_W  = 16;
	localparam int unsigned DIV_STEP_W = 5;

	// Step counts (two bits each) for the three divisions.
	localparam logic [DIV_STEP_W-1:0] STEPS_CHARGE  = 5'd17;
	localparam logic [DIV_STEP_W-1:0] STEPS_LIFE    = 5'd12;
	localparam logic [DIV_STEP_W-1:0] STEPS_MINUTES = 5'd11;

	// Scale factors applied to the remaining capacity.
	localparam logic [32:0] SCALE_CHARGE  = 33'd100000;
	localparam logic [23:0] SCALE_LIFE    = 24'd100;
	localparam logic [21:0] SCALE_MINUTES = 22'd60;

	localparam logic [15:0] CAP_UNKNOWN = 16'hFFFF;

	// Register bit positions.
	localparam int unsigned FLAG_PRESENT_BIT = 0;
	localparam int unsigned FLAG_AC_BIT      = 2;
	localparam int unsigned ST_CHARGING_BIT  = 1;
	localparam int unsigned ST_FULL_BIT      = 3;

	// Life thresholds for the battery class.
	localparam logic [22:0] LIFE_HIGH_LIMIT = 23'd50;
	localparam logic [22:0] LIFE_LOW_LIMIT  = 23'd25;

	// AC state codes.
	localparam logic [1:0] AC_UNKNOWN = 2'd0;
	localparam logic [1:0] AC_OFF     = 2'd1;
	localparam logic [1:0] AC_ON      = 2'd2;

	// Battery state codes.
	localparam logic [2:0] BS_UNKNOWN  = 3'd0;
	localparam logic [2:0] BS_ABSENT   = 3'd1;
	localparam logic [2:0] BS_HIGH     = 3'd2;
	localparam logic [2:0] BS_LOW      = 3'd3;
	localparam logic [2:0] BS_CRITICAL = 3'd4;
	localparam logic [2:0] BS_CHARGING = 3'd5;

	// Command from the sequencer to the divider.
	typedef struct packed {
		logic                  start;
		logic [DIV_STEP_W-1:0] steps;
	} div_cmd_t;

endpackage

@@ rtl/bsr_div.sv @@
// ----------------------------------------------------------------------------
// bsr_div: radix-4 restoring divider
// The dividend is shifted in from its top end two bits per cycle while the
// partial remainder is compared against the divisor and reduced.
// ----------------------------------------------------------------------------
module bsr_div
	import bsr_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  div_cmd_t             cmd,
	input  logic [DIV_NUM_W-1:0] dividend,
	input  logic [DIV_DEN_W-1:0] divisor,
	output logic                 done,
	output logic [DIV_NUM_W-1:0] quotient
);

	logic [DIV_NUM_W-1:0]  num_q;
	logic [DIV_NUM_W-1:0]  quo_q;
	logic [DIV_DEN_W-1:0]  den_q;
	logic [DIV_DEN_W-1:0]  rem_q;
	logic [DIV_STEP_W-1:0] cnt_q;
	logic                  busy_q;
	logic                  done_q;
	logic [DIV_DEN_W+1:0]  step_res;

	// Two restoring steps; returns the new remainder and two quotient bits.
	function automatic logic [DIV_DEN_W+1:0] div_step2(
		input logic [DIV_DEN_W-1:0] rem,
		input logic [1:0]           bits,
		input logic [DIV_DEN_W-1:0] den
	);
		logic [DIV_DEN_W:0]   t;
		logic [DIV_DEN_W-1:0] r;
		logic                 q1;
		logic                 q0;
		t = {rem, bits[1]};
		if (t >= {1'b0, den}) begin
			r  = DIV_DEN_W'(t - {1'b0, den});
			q1 = 1'b1;
		end else begin
			r  = t[DIV_DEN_W-1:0];
			q1 = 1'b0;
		end
		t = {r, bits[0]};
		if (t >= {1'b0, den}) begin
			r  = DIV_DEN_W'(t - {1'b0, den});
			q0 = 1'b1;
		end else begin
			r  = t[DIV_DEN_W-1:0];
			q0 = 1'b0;
		end
		return {r, q1, q0};
	endfunction

	assign step_res = div_step2(rem_q, num_q[DIV_NUM_W-1 -: 2], den_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (cmd.start) begin
				busy_q <= 1'b1;
				cnt_q  <= cmd.steps;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == DIV_STEP_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			num_q <= dividend;
			den_q <= divisor;
			rem_q <= '0;
			quo_q <= '0;
		end else if (busy_q) begin
			num_q <= {num_q[DIV_NUM_W-3:0], 2'b00};
			rem_q <= step_res[DIV_DEN_W+1:2];
			quo_q <= {quo_q[DIV_NUM_W-3:0], step_res[1:0]};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

@@ rtl/battery_status_reporter.sv @@
// Input transactions are taken one at a time: in_stall holds off the next one until
// the last result is loaded into the output register. The shared divider retires
// two quotient bits a cycle over three divisions of 17, 12 and 11 steps.
// A finished result waits in the output register while the next input is taken.
// Reset (arst_n low) clears the snapshot latch, so results read as unknown until
// the first good read.
// ----------------------------------------------------------------------------
// battery_status_reporter: battery poll snapshot to status report
// Latches each good poll (capacity fallbacks applied), then derives charge in
// milli-percent, percent life and minutes left through one shared divider.
// ----------------------------------------------------------------------------
module battery_status_reporter
	import bsr_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	// Input channel.
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               read_ok,
	input  logic [7:0]         flag_byte,
	input  logic [7:0]         status_byte,
	input  logic [15:0]        remaining_raw,
	input  logic [15:0]        voltage_raw,
	input  logic signed [15:0] current_raw,
	input  logic [15:0]        design_cap_raw,
	input  logic [15:0]        full_cap_raw,
	// Output channel.
	output logic               out_valid,
	input  logic               out_stall,
	output logic               sensors_valid,
	output logic               charge_valid,
	output logic [32:0]        charge_millipercent,
	output logic [15:0]        remaining_mah,
	output logic [15:0]        full_mah,
	output logic [15:0]        design_mah,
	output logic [15:0]        voltage_mv,
	output logic signed [15:0] current_ma,
	output logic [1:0]         ac_status,
	output logic [2:0]         battery_class,
	output logic [22:0]        life_percent,
	output logic signed [22:0] runtime_minutes
);

	// Sequencer: one division per state, then the result is moved to the
	// output register.
	typedef enum logic [4:0] {
		ST_IDLE    = 5'b00001,
		ST_CHARGE  = 5'b00010,
		ST_LIFE    = 5'b00100,
		ST_MINUTES = 5'b01000,
		ST_OUT     = 5'b10000
	} state_t;

	state_t state_q;
	logic   go_q;

	// Snapshot latch.
	logic        have_snapshot_q;
	logic        present_flag_q;
	logic        ac_flag_q;
	logic [7:0]  kept_status_q;
	logic [15:0] kept_remaining_q;
	logic [15:0] kept_voltage_q;
	logic [15:0] kept_current_q;
	logic [15:0] kept_full_q;
	logic [15:0] kept_design_q;
	logic        ok_q;

	// Quotients of the current transaction.
	logic [32:0] charge_q;
	logic [22:0] life_q;
	logic [21:0] minutes_q;

	// Output register.
	logic               out_valid_q;
	logic               sensors_valid_q;
	logic               charge_valid_q;
	logic [32:0]        charge_mp_q;
	logic [15:0]        remaining_q;
	logic [15:0]        full_q;
	logic [15:0]        design_q;
	logic [15:0]        voltage_q;
	logic signed [15:0] current_q;
	logic [1:0]         ac_status_q;
	logic [2:0]         battery_class_q;
	logic [22:0]        life_percent_q;
	logic signed [22:0] runtime_minutes_q;

	// Divider connection.
	div_cmd_t             div_cmd;
	logic [DIV_NUM_W-1:0] div_dividend;
	logic [DIV_DEN_W-1:0] div_divisor;
	logic                 div_done;
	logic [DIV_NUM_W-1:0] div_quotient;

	logic        in_accept;
	logic        out_load;
	logic [15:0] rem_mapped;
	logic [15:0] des_mapped;
	logic [15:0] full_mapped;
	logic [15:0] full_eff;
	logic [32:0] charge_num;
	logic [23:0] life_num;
	logic [21:0] minutes_num;
	logic [15:0] draw;

	// Result fields built from the latch and the quotients.
	logic        full_nz;
	logic        charging;
	logic        chg_valid_d;
	logic [1:0]  ac_d;
	logic [2:0]  bs_d;
	logic [22:0] life_d;
	logic [22:0] minutes_d;

	assign in_accept = in_valid && !in_stall;
	// New polls are taken only between transactions; the output register
	// keeps a finished result on its own.
	assign in_stall  = (state_q != ST_IDLE);
	assign out_load  = (state_q == ST_OUT) && (!out_valid_q || !out_stall);

	// Capacity fallbacks: unknown reads as zero, and a missing full-charge
	// capacity falls back to the design capacity.
	assign rem_mapped  = (remaining_raw == CAP_UNKNOWN) ? 16'd0 : remaining_raw;
	assign des_mapped  = (design_cap_raw == CAP_UNKNOWN) ? 16'd0 : design_cap_raw;
	assign full_mapped = (full_cap_raw == CAP_UNKNOWN) ? 16'd0 : full_cap_raw;
	assign full_eff    = (full_mapped == 16'd0) ? des_mapped : full_mapped;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			have_snapshot_q  <= 1'b0;
			present_flag_q   <= 1'b0;
			ac_flag_q        <= 1'b0;
			kept_status_q    <= '0;
			kept_remaining_q <= '0;
			kept_voltage_q   <= '0;
			kept_current_q   <= '0;
			kept_full_q      <= '0;
			kept_design_q    <= '0;
		end else if (in_accept && read_ok) begin
			have_snapshot_q  <= 1'b1;
			present_flag_q   <= flag_byte[FLAG_PRESENT_BIT];
			ac_flag_q        <= flag_byte[FLAG_AC_BIT];
			kept_status_q    <= status_byte;
			kept_remaining_q <= rem_mapped;
			kept_voltage_q   <= voltage_raw;
			kept_current_q   <= current_raw;
			kept_full_q      <= full_eff;
			kept_design_q    <= des_mapped;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			ok_q <= read_ok;
		end
	end

	// Scaled dividends, aligned so that their top bit enters the divider
	// first. The draw is the magnitude of a negative current; its value does
	// not matter otherwise, since the minutes are then masked.
	assign charge_num  = SCALE_CHARGE * 33'(kept_remaining_q);
	assign life_num    = SCALE_LIFE * 24'(kept_remaining_q);
	assign minutes_num = SCALE_MINUTES * 22'(kept_remaining_q);
	assign draw        = 16'(~kept_current_q + 16'd1);

	always_comb begin
		div_cmd.start = go_q;
		div_cmd.steps = STEPS_CHARGE;
		div_dividend  = {1'b0, charge_num};
		div_divisor   = kept_full_q;
		unique case (state_q)
			ST_LIFE: begin
				div_cmd.steps = STEPS_LIFE;
				div_dividend  = {life_num, 10'd0};
			end
			ST_MINUTES: begin
				div_cmd.steps = STEPS_MINUTES;
				div_dividend  = {minutes_num, 12'd0};
				div_divisor   = draw;
			end
			default: begin
				div_cmd.steps = STEPS_CHARGE;
			end
		endcase
	end

	bsr_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (div_cmd),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.done     (div_done),
		.quotient (div_quotient)
	);

	// Sequencer. go_q pulses for one cycle on entry to each division state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			go_q    <= 1'b0;
		end else begin
			go_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (in_accept) begin
						state_q <= ST_CHARGE;
						go_q    <= 1'b1;
					end
				end
				ST_CHARGE: begin
					if (div_done) begin
						state_q <= ST_LIFE;
						go_q    <= 1'b1;
					end
				end
				ST_LIFE: begin
					if (div_done) begin
						state_q <= ST_MINUTES;
						go_q    <= 1'b1;
					end
				end
				ST_MINUTES: begin
					if (div_done) begin
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (div_done) begin
			unique case (state_q)
				ST_CHARGE:  charge_q  <= div_quotient[32:0];
				ST_LIFE:    life_q    <= div_quotient[22:0];
				ST_MINUTES: minutes_q <= div_quotient[21:0];
				default: begin
				end
			endcase
		end
	end

	// Report fields. Before the first good read everything is unknown; an
	// absent battery reports zero life and all ones (-1) for the minutes left.
	assign full_nz     = (kept_full_q != 16'd0);
	assign charging    = kept_status_q[ST_CHARGING_BIT];
	assign chg_valid_d = ok_q && full_nz;
	assign life_d      = (have_snapshot_q && present_flag_q && full_nz) ? life_q : 23'd0;
	assign ac_d        = !have_snapshot_q ? AC_UNKNOWN : (ac_flag_q ? AC_ON : AC_OFF);
	assign minutes_d   = (have_snapshot_q && present_flag_q && !charging
			&& kept_current_q[15]) ? {1'b0, minutes_q} : '1;

	always_comb begin
		priority if (!have_snapshot_q) begin
			bs_d = BS_UNKNOWN;
		end else if (!present_flag_q) begin
			bs_d = BS_ABSENT;
		end else if (kept_status_q[ST_FULL_BIT]) begin
			bs_d = BS_HIGH;
		end else if (charging) begin
			bs_d = BS_CHARGING;
		end else if (life_d > LIFE_HIGH_LIMIT) begin
			bs_d = BS_HIGH;
		end else if (life_d > LIFE_LOW_LIMIT) begin
			bs_d = BS_LOW;
		end else begin
			bs_d = BS_CRITICAL;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			sensors_valid_q   <= ok_q;
			charge_valid_q    <= chg_valid_d;
			charge_mp_q       <= chg_valid_d ? charge_q : 33'd0;
			remaining_q       <= kept_remaining_q;
			full_q            <= kept_full_q;
			design_q          <= kept_design_q;
			voltage_q         <= kept_voltage_q;
			current_q         <= kept_current_q;
			ac_status_q       <= ac_d;
			battery_class_q   <= bs_d;
			life_percent_q    <= life_d;
			runtime_minutes_q <= minutes_d;
		end
	end

	assign out_valid           = out_valid_q;
	assign sensors_valid       = sensors_valid_q;
	assign charge_valid        = charge_valid_q;
	assign charge_millipercent = charge_mp_q;
	assign remaining_mah       = remaining_q;
	assign full_mah            = full_q;
	assign design_mah          = design_q;
	assign voltage_mv          = voltage_q;
	assign current_ma          = current_q;
	assign ac_status           = ac_status_q;
	assign battery_class       = battery_class_q;
	assign life_percent        = life_percent_q;
	assign runtime_minutes     = runtime_minutes_q;

endmodule
